>>> rtl/bqf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqf_pkg: types and constants for the box query filter
// Coordinate width, result widths, register indexes and the beat structs
// that travel on the entry and result channels.
// ----------------------------------------------------------------------------
package bqf_pkg;

    // Coordinate width; every coordinate is two's complement
    localparam int COORD_BITS   = 16;
    // Result field widths
    localparam int AREA_BITS    = 32;
    localparam int DIST_BITS    = 33;
    // Configuration port
    localparam int CFG_IDX_BITS = 3;
    localparam int DIMS_BITS    = 2;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic [CFG_IDX_BITS-1:0]      cfg_idx_t;
    typedef logic [DIMS_BITS-1:0]         dims_t;

    // Register indexes
    localparam cfg_idx_t REG_QUERY_LOW_X  = cfg_idx_t'(0);
    localparam cfg_idx_t REG_QUERY_LOW_Y  = cfg_idx_t'(1);
    localparam cfg_idx_t REG_QUERY_HIGH_X = cfg_idx_t'(2);
    localparam cfg_idx_t REG_QUERY_HIGH_Y = cfg_idx_t'(3);
    localparam cfg_idx_t REG_DIMS_IN_USE  = cfg_idx_t'(4);

    // Reset value of the axis count
    localparam dims_t DIMS_RESET = dims_t'(2);

    // One entry box per input beat
    typedef struct packed {
        coord_t entry_low_x;
        coord_t entry_low_y;
        coord_t entry_high_x;
        coord_t entry_high_y;
    } entry_t;

    // One result per entry
    typedef struct packed {
        logic                 overlaps;
        logic                 entry_holds_query;
        logic                 query_holds_entry;
        logic                 edges_touch;
        logic [AREA_BITS-1:0] overlap_area;
        logic [DIST_BITS-1:0] gap_distance_sq;
        logic                 entry_invalid;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/box_query_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// box_query_filter: entry box test against a configured query box
// Overlap, containment both ways, edge touch, overlap area, squared gap
// distance and an inverted-entry flag for every entry box.
//
//   channel   direction  handshake                       payload
//   entry     in         entry_valid / entry_ready       entry (entry_t)
//   result    out        result_valid / result_ready     result (result_t)
//   cfg       in         cfg_valid / cfg_ready           cfg_index, cfg_data
//
// An entry beat reaches its result beat through two registers: the entry
// register, then the compare/multiply logic into the result register.
// One entry is taken every cycle while results drain.
// The entry register keeps taking beats while a result waits, until both
// registers are full. cfg_ready is always high.
// Reset clears the query box to zero and the axis count to two.
// ----------------------------------------------------------------------------
module box_query_filter
    import bqf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    // entry channel
    input  wire logic     entry_valid,
    output logic          entry_ready,
    input  wire entry_t   entry,
    // result channel
    output logic          result_valid,
    input  wire logic     result_ready,
    output result_t       result,
    // configuration channel
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire cfg_idx_t cfg_index,
    input  wire logic [COORD_BITS-1:0] cfg_data
);

    localparam int LEN_BITS  = COORD_BITS;
    localparam int PROD_BITS = 2 * COORD_BITS;
    localparam int SUM_BITS  = 2 * COORD_BITS + 1;

    typedef logic signed [COORD_BITS:0] diff_t;
    typedef logic [LEN_BITS-1:0]        len_t;
    typedef logic [PROD_BITS-1:0]       prod_t;

    // per-axis compare results
    typedef struct packed {
        logic ovl;
        logic ehq;
        logic qhe;
        logic touch;
        logic inv;
        len_t len;
        len_t gap;
    } axis_t;

    // configuration registers
    coord_t  q_low_x_reg, q_low_y_reg, q_high_x_reg, q_high_y_reg;
    dims_t   dims_reg;

    // entry register
    logic    ent_valid_reg;
    entry_t  ent_reg;

    // result register
    logic    res_valid_reg;
    result_t res_reg;

    logic    res_load;
    logic    use_y;
    axis_t   ax_x, ax_y;
    prod_t   area_prod, sq_x, sq_y;
    logic [SUM_BITS-1:0] dist_sum;
    result_t res_next;

    // per-axis compares, overlap length and gap
    function automatic axis_t axis_eval(coord_t el, coord_t eh, coord_t ql, coord_t qh);
        axis_t  a;
        coord_t lo, hi;
        diff_t  len_d, gap_hi, gap_lo;
        a.ovl   = !((eh < ql) || (el > qh));
        a.ehq   = !((el > ql) || (eh < qh));
        a.qhe   = !((ql > el) || (qh < eh));
        a.touch = (el == ql) || (eh == qh);
        a.inv   = el > eh;
        lo      = (el > ql) ? el : ql;
        hi      = (eh < qh) ? eh : qh;
        len_d   = diff_t'(hi) - diff_t'(lo);
        a.len   = len_d[COORD_BITS] ? '0 : len_d[LEN_BITS-1:0];
        gap_hi  = diff_t'(el) - diff_t'(qh);
        gap_lo  = diff_t'(ql) - diff_t'(eh);
        if (qh < el)
            a.gap = gap_hi[LEN_BITS-1:0];
        else if (ql > eh)
            a.gap = gap_lo[LEN_BITS-1:0];
        else
            a.gap = '0;
        return a;
    endfunction

    // configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_low_x_reg  <= '0;
            q_low_y_reg  <= '0;
            q_high_x_reg <= '0;
            q_high_y_reg <= '0;
            dims_reg     <= DIMS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_QUERY_LOW_X:  q_low_x_reg  <= cfg_data;
                REG_QUERY_LOW_Y:  q_low_y_reg  <= cfg_data;
                REG_QUERY_HIGH_X: q_high_x_reg <= cfg_data;
                REG_QUERY_HIGH_Y: q_high_y_reg <= cfg_data;
                REG_DIMS_IN_USE:  dims_reg     <= cfg_data[DIMS_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // handshake: entry register refills as the result register loads
    assign res_load    = ent_valid_reg && (!res_valid_reg || result_ready);
    assign entry_ready = !ent_valid_reg || !res_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ent_valid_reg <= 1'b0;
        else if (entry_ready)
            ent_valid_reg <= entry_valid;
    end

    always_ff @(posedge clk)
    begin
        if (entry_valid && entry_ready)
            ent_reg <= entry;
    end

    // axis count: 0 acts as 1, 3 acts as 2
    assign use_y = dims_reg[1];

    assign ax_x = axis_eval(ent_reg.entry_low_x, ent_reg.entry_high_x,
                            q_low_x_reg, q_high_x_reg);
    assign ax_y = axis_eval(ent_reg.entry_low_y, ent_reg.entry_high_y,
                            q_low_y_reg, q_high_y_reg);

    // area product and squared gaps, all in parallel
    assign area_prod = use_y ? prod_t'(ax_x.len) * prod_t'(ax_y.len) : prod_t'(ax_x.len);
    assign sq_x      = prod_t'(ax_x.gap) * prod_t'(ax_x.gap);
    assign sq_y      = prod_t'(ax_y.gap) * prod_t'(ax_y.gap);
    assign dist_sum  = {1'b0, sq_x} + (use_y ? {1'b0, sq_y} : '0);

    // result assembly
    always_comb
    begin
        res_next.overlaps          = ax_x.ovl   && (!use_y || ax_y.ovl);
        res_next.entry_holds_query = ax_x.ehq   && (!use_y || ax_y.ehq);
        res_next.query_holds_entry = ax_x.qhe   && (!use_y || ax_y.qhe);
        res_next.edges_touch       = ax_x.touch || (use_y && ax_y.touch);
        res_next.entry_invalid     = ax_x.inv   || (use_y && ax_y.inv);
        res_next.overlap_area      = res_next.overlaps ? AREA_BITS'(area_prod) : '0;
        res_next.gap_distance_sq   = DIST_BITS'(dist_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (res_load)
            res_valid_reg <= 1'b1;
        else if (result_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // checks
    a_result_from_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(ent_valid_reg))
        else $error("result beat without a held entry");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid_reg |-> entry_ready)
        else $error("entry stalled with empty result register");

    a_disjoint_no_area: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (!res_reg.overlaps || res_reg.entry_invalid))
            |-> (res_reg.overlap_area == '0))
        else $error("nonzero area for disjoint or inverted entry");

    a_overlap_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.overlaps) |-> (res_reg.gap_distance_sq == '0))
        else $error("nonzero gap for overlapping boxes");

endmodule
`default_nettype wire
